@@ src/ple_pkg.sv @@
package ple_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  // controller -> datapath, one transaction's worth of work
  typedef struct packed {
    logic exec;
    logic ins;
    logic rem;
    logic wr;
    logic clr;
    logic rd;
    st_t  st;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pos_le_cnt;
    logic pos_lt_cnt;
    logic full;
  } stat_t;

endpackage

@@ src/ple_in_if.sv @@
interface ple_in_if import ple_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, output opcode, output position, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input write_value,
                  output ready);
endinterface

@@ src/ple_out_if.sv @@
interface ple_out_if import ple_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic [LEN_W-1:0] length;
  logic [ST_W-1:0]  status;

  modport source (output valid, output read_value, output length, output status,
                  input ready);
  modport sink   (input valid, input read_value, input length, input status,
                  output ready);
endinterface

@@ src/ple_ctrl.sv @@
module ple_ctrl import ple_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic [OP_W-1:0] opcode,
  input  stat_t           stat,
  output cmd_t            cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_RESP);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // opcode decode; range check ahead of the full check on insert
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_OK;
    if (accept) begin
      cmd.exec = 1'b1;
      unique case (op_t'(opcode))
        OP_INSERT: begin
          if (!stat.pos_le_cnt)  cmd.st  = ST_RANGE;
          else if (stat.full)    cmd.st  = ST_FULL;
          else                   cmd.ins = 1'b1;
        end
        OP_REMOVE: begin
          if (!stat.pos_lt_cnt)  cmd.st  = ST_RANGE;
          else                   cmd.rem = 1'b1;
        end
        OP_READ: begin
          if (!stat.pos_lt_cnt)  cmd.st  = ST_RANGE;
          else                   cmd.rd  = 1'b1;
        end
        OP_WRITE: begin
          if (!stat.pos_lt_cnt)  cmd.st  = ST_RANGE;
          else                   cmd.wr  = 1'b1;
        end
        OP_CLEAR:                cmd.clr = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ src/ple_dp.sv @@
module ple_dp import ple_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [POS_W-1:0] position,
  input  logic [VAL_W-1:0] write_value,
  output stat_t            stat,
  output logic [VAL_W-1:0] read_value,
  output logic [LEN_W-1:0] length,
  output logic [ST_W-1:0]  status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int MW    = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_BITS-1:0] cell_r [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;
  logic [VAL_W-1:0]      read_value_r;
  logic [LEN_W-1:0]      length_r;
  logic [ST_W-1:0]       status_r;

  logic [PW-1:0]         pos_p;
  logic [IDX_W-1:0]      idx;
  logic [MW-1:0]         pos_m, cnt_m;
  logic [63:0]           wv64, rd64;
  logic [VALUE_BITS-1:0] wv;
  logic [31:0]           len32;

  assign pos_p = PW'(position);
  assign idx   = pos_p[IDX_W-1:0];
  assign pos_m = MW'(position);
  assign cnt_m = MW'(count_r);
  assign wv64  = 64'(write_value);
  assign wv    = wv64[VALUE_BITS-1:0];
  assign rd64  = 64'(cell_r[idx]);

  assign stat.pos_le_cnt = (pos_m <= cnt_m);
  assign stat.pos_lt_cnt = (pos_m <  cnt_m);
  assign stat.full       = (count_r == CW'(CAPACITY));

  // cell chain: on insert or remove, the entries from the position up all shift in the same cycle
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] from_lo, from_hi;
    logic                  above, at;

    if (i == 0) begin : g_lo_end
      assign from_lo = cell_r[i];
    end else begin : g_lo
      assign from_lo = cell_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_end
      assign from_hi = cell_r[i];
    end else begin : g_hi
      assign from_hi = cell_r[i+1];
    end

    assign above = (PW'(i) > pos_p);
    assign at    = (PW'(i) == pos_p);

    always_ff @(posedge clk) begin
      if (cmd.ins && above) begin
        cell_r[i] <= from_lo;
      end else if ((cmd.ins || cmd.wr) && at) begin
        cell_r[i] <= wv;
      end else if (cmd.rem && (above || at)) begin
        cell_r[i] <= from_hi;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr)      count_nxt = '0;
    else if (cmd.ins) count_nxt = count_r + 1'b1;
    else if (cmd.rem) count_nxt = count_r - 1'b1;
  end

  assign len32 = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value_r <= cmd.rd ? rd64[VAL_W-1:0] : '0;
      length_r     <= len32[LEN_W-1:0];
      status_r     <= cmd.st;
    end
  end

  assign read_value = read_value_r;
  assign length     = length_r;
  assign status     = status_r;

endmodule

@@ src/positional_list_engine_top.sv @@
// A result is valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while out_ch.ready stays high; the cell
//   chain shifts from the position up at once; the result register holds one.
// Reset (rst_n low, synchronous): list length and handshake state clear;
//   stored entries are not cleared and carry no meaning beyond the length.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: handshake state and opcode decode. It owns in_ready, which
  // opens again in the same cycle the pending result is taken.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .opcode    (in_ch.opcode),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the cell chain, the length counter, the position compares
  // and the result register.
  ple_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .position    (in_ch.position),
    .write_value (in_ch.write_value),
    .stat        (stat),
    .read_value  (out_ch.read_value),
    .length      (out_ch.length),
    .status      (out_ch.status)
  );

  // An accepted transaction always shows up as a result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted transaction produced no result");

  // A full-list refusal only happens at capacity.
  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |-> (out_ch.length == LEN_W'(CAPACITY)))
    else $error("full status with length below capacity");

  // Only a successful read returns a nonzero value.
  a_value_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_value != '0) |-> (out_ch.status == ST_OK))
    else $error("nonzero read value on a failed transaction");

  // Clear empties the list.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.opcode == OP_CLEAR)
      |=> (out_ch.length == '0 && out_ch.status == ST_OK))
    else $error("clear left entries in the list");

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;

  // steady stretch: both sides run flat out between these cycle counts
  localparam int STEADY_FROM = 600;
  localparam int STEADY_TO   = 1200;

  localparam int SEG_LEN   = 50;
  localparam int SEG_COUNT = 27;
  localparam int PAUSE_SEG = 10;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  typedef struct {
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] write_value;
  } list_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
    logic [ST_W-1:0]  status;
  } list_result_t;

  logic clk;
  logic rst_n;
  int   cyc;
  logic steady;
  int   fail_count;

  list_cmd_t        pending_cmds[$];      // commands not yet offered to the DUT
  list_result_t     expected_results[$];  // one per accepted transaction, oldest first
  logic [VAL_W-1:0] shadow_list[$];       // list contents as the DUT should hold them
  int unsigned      plan_len;             // list length the generator assumes

  ple_in_if  in_if ();
  ple_out_if out_if ();

  positional_list_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // ---------------------------------------------------------------------------
  // clock, reset, cycle count
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.position = '0;
    in_if.write_value = '0;
    out_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  initial cyc = 0;

  assign steady = (cyc >= STEADY_FROM) && (cyc < STEADY_TO);

  // ---------------------------------------------------------------------------
  // Shadow list. It applies one command and returns what the DUT should report.
  // Failed operations leave the list alone. Insert checks range before full.
  // ---------------------------------------------------------------------------
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op_bits,
                                                 logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  n;
    r = '0;
    n = shadow_list.size();
    r.status = ST_OK;
    case (op_bits)
      OP_INSERT: begin
        if (pos > n) r.status = ST_RANGE;
        else if (n >= LIST_CAP) r.status = ST_FULL;
        else shadow_list.insert(int'(pos), val);
      end
      OP_REMOVE: begin
        if (pos >= n) r.status = ST_RANGE;
        else shadow_list.delete(int'(pos));
      end
      OP_READ: begin
        if (pos >= n) r.status = ST_RANGE;
        else r.read_value = shadow_list[pos];
      end
      OP_WRITE: begin
        if (pos >= n) r.status = ST_RANGE;
        else shadow_list[pos] = val;
      end
      OP_CLEAR: shadow_list.delete();
      default: ;  // opcodes 5..7 do nothing
    endcase
    r.length = LEN_W'(shadow_list.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning: length tracking keeps positions relevant to the list
  // ---------------------------------------------------------------------------
  task automatic plan_cmd(logic [OP_W-1:0] op_bits, int unsigned pos,
                          logic [VAL_W-1:0] val);
    list_cmd_t c;
    c.opcode = op_bits;
    c.position = POS_W'(pos);
    c.write_value = val;
    pending_cmds.push_back(c);
    case (op_bits)
      OP_INSERT: if (pos <= plan_len && plan_len < LIST_CAP) plan_len++;
      OP_REMOVE: if (pos < plan_len) plan_len--;
      OP_CLEAR:  plan_len = 0;
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_pos(logic [OP_W-1:0] op_bits);
    int unsigned roll;
    int unsigned p;
    roll = $urandom_range(0, 99);
    if (op_bits != OP_INSERT && plan_len == 0) return $urandom_range(0, 63);
    if (op_bits > OP_WRITE) return $urandom_range(0, 63);
    if (roll < 80) begin
      p = (op_bits == OP_INSERT) ? $urandom_range(0, plan_len)
                                 : $urandom_range(0, plan_len - 1);
    end else if (roll < 90) begin
      // first position past the end
      p = (op_bits == OP_INSERT) ? plan_len + 1 : plan_len;
      if (p > 63) p = $urandom_range(0, 63);
    end else begin
      p = $urandom_range(0, 63);
    end
    return p;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int unsigned roll;
    int unsigned lim_ins, lim_rem, lim_rd, lim_wr, lim_clr;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin lim_ins = 72; lim_rem = 80; lim_rd = 89; lim_wr = 96; lim_clr = 97; end
      MIX_DRAIN: begin lim_ins = 15; lim_rem = 65; lim_rd = 80; lim_wr = 92; lim_clr = 95; end
      default:   begin lim_ins = 35; lim_rem = 60; lim_rd = 78; lim_wr = 92; lim_clr = 96; end
    endcase
    if (roll < lim_ins) return OP_INSERT;
    if (roll < lim_rem) return OP_REMOVE;
    if (roll < lim_rd)  return OP_READ;
    if (roll < lim_wr)  return OP_WRITE;
    if (roll < lim_clr) return OP_CLEAR;
    return OP_W'($urandom_range(5, 7));
  endfunction

  // waits until the DUT has nothing in flight and nothing is left to send
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    mix_t        mix;
    logic [OP_W-1:0] op_bits;
    int unsigned roll;

    fail_count = 0;
    plan_len = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, append, front insert, bounds, undefined opcodes, clear
    plan_cmd(OP_READ,   0,  '0);             // read on empty list
    plan_cmd(OP_REMOVE, 0,  '0);             // remove on empty list
    plan_cmd(OP_INSERT, 1,  32'h1234_5678);  // insert past end
    plan_cmd(OP_INSERT, 0,  32'h0000_0000);
    plan_cmd(OP_INSERT, 1,  32'hFFFF_FFFF);  // append
    plan_cmd(OP_INSERT, 0,  32'hA5A5_A5A5);  // front insert shifts both up
    plan_cmd(OP_INSERT, 63, 32'hDEAD_BEEF);  // far out of range
    plan_cmd(OP_READ,   0,  '0);
    plan_cmd(OP_READ,   1,  '0);
    plan_cmd(OP_READ,   2,  '0);
    plan_cmd(OP_READ,   3,  '0);             // one past the end
    plan_cmd(OP_WRITE,  1,  32'h5A5A_5A5A);
    plan_cmd(OP_WRITE,  63, 32'hFFFF_FFFF);  // overwrite out of range
    plan_cmd(OP_READ,   1,  '0);
    plan_cmd(OP_REMOVE, 63, '0);             // remove out of range
    plan_cmd(OP_REMOVE, 0,  '0);             // front remove
    plan_cmd(OP_REMOVE, 1,  '0);             // last entry
    plan_cmd(OP_READ,   0,  '0);
    plan_cmd(3'd5,      42, 32'hFFFF_FFFF);  // undefined opcodes
    plan_cmd(3'd6,      21, 32'h0F0F_0F0F);
    plan_cmd(3'd7,      63, 32'hF0F0_F0F0);
    plan_cmd(OP_CLEAR,  0,  '0);
    plan_cmd(OP_CLEAR,  63, '0);             // clear on empty list
    plan_cmd(OP_INSERT, 0,  32'h8000_0001);
    plan_cmd(OP_READ,   0,  '0);

    // random segments; the first two fill the list so full inserts show up
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg < 2) begin
        mix = MIX_FILL;
      end else begin
        roll = $urandom_range(0, 9);
        mix = (roll < 4) ? MIX_FILL : (roll < 7) ? MIX_DRAIN : MIX_BALANCED;
      end
      for (int k = 0; k < SEG_LEN; k++) begin
        op_bits = pick_op(mix);
        plan_cmd(op_bits, pick_pos(op_bits), pick_value());
      end
      // sender holds off once until every outstanding result is back
      if (seg == PAUSE_SEG) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: valid holds until the transaction is taken; the accepted command
  // goes through the shadow list at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    list_cmd_t c;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(
          apply_list_op(in_if.opcode, in_if.position, in_if.write_value));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          c = pending_cmds.pop_front();
          in_if.valid       <= 1'b1;
          in_if.opcode      <= c.opcode;
          in_if.position    <= c.position;
          in_if.write_value <= c.write_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transaction is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    list_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%t: result with nothing expected: read_value %h length %0d status %0d",
                   $realtime, out_if.read_value, out_if.length, out_if.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.read_value !== want.read_value) begin
            $display("%t: read_value expected %h actual %h",
                     $realtime, want.read_value, out_if.read_value);
            fail_count++;
          end
          if (out_if.length !== want.length) begin
            $display("%t: length expected %0d actual %0d",
                     $realtime, want.length, out_if.length);
            fail_count++;
          end
          if (out_if.status !== want.status) begin
            $display("%t: status expected %0d actual %0d",
                     $realtime, want.status, out_if.status);
            fail_count++;
          end
        end
      end
      out_if.ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

endmodule
